FILE: hdl/tlc_pkg.sv
// Shared constants, codes and controller/datapath types for the layout address generator.
`default_nettype none

package tlc_pkg;

  localparam int CHANNEL_LANES_DEF = 16;
  localparam int WIDTH_LANES_DEF   = 8;
  localparam int MAX_DIM_DEF       = 1024;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int IMG_W      = 4;
  localparam int IMGN_W     = 5;
  localparam int MAX_IMAGES = 16;
  localparam int DEST_W     = 34;
  localparam int SRC_W      = 31;

  localparam int RST_CHANNELS = 3;
  localparam int RST_HEIGHT   = 224;
  localparam int RST_WIDTH    = 224;
  localparam int RST_IMAGES   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT,
    REG_HEIGHT,
    REG_WIDTH,
    REG_IMAGE_COUNT,
    REG_IDENTITY_MODE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRC_ROW,
    ST_SRC_COL,
    ST_DST_GRP,
    ST_DST_ROW,
    ST_DST_COL,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    MAC_HOLD,
    MAC_SRC_ROW,
    MAC_SRC_COL,
    MAC_DST_GRP,
    MAC_DST_ROW,
    MAC_DST_COL
  } mac_op_t;

  typedef struct packed {
    logic    accept;
    mac_op_t op;
    logic    emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/tlc_in_if.sv
// Request channel carrying the restart flag.
`default_nettype none

interface tlc_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

FILE: hdl/tlc_out_if.sv
// Result channel carrying the destination and source addresses and flags.
`default_nettype none

interface tlc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tlc_pkg::DEST_W-1:0]  dest_addr;
  logic [tlc_pkg::SRC_W-1:0]   src_addr;
  logic                        zero_fill;
  logic                        last_element;

  modport source (output valid, output dest_addr, output src_addr, output zero_fill,
                  output last_element, input ready);
  modport sink (input valid, input dest_addr, input src_addr, input zero_fill,
                input last_element, output ready);
endinterface

`default_nettype wire

FILE: hdl/tlc_cfg_if.sv
// Configuration write channel carrying a register index and write data.
`default_nettype none

interface tlc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tlc_pkg::CFG_IDX_W-1:0]  index;
  logic [tlc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tlc_cfg.sv
// Configuration registers with clamped dimensions and precomputed group counts.
`default_nettype none

module tlc_cfg #(
  parameter int CHANNEL_LANES = tlc_pkg::CHANNEL_LANES_DEF,
  parameter int WIDTH_LANES   = tlc_pkg::WIDTH_LANES_DEF,
  parameter int MAX_DIM       = tlc_pkg::MAX_DIM_DEF,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int CGMAX = (MAX_DIM + CHANNEL_LANES - 1) / CHANNEL_LANES,
  localparam int WGMAX = (MAX_DIM + WIDTH_LANES - 1) / WIDTH_LANES,
  localparam int CG_W  = $clog2(CGMAX + 1),
  localparam int WG_W  = $clog2(WGMAX + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  tlc_cfg_if.sink                   cfg_chan,
  output logic [DIM_W-1:0]          c_lim,
  output logic [DIM_W-1:0]          h_lim,
  output logic [DIM_W-1:0]          w_lim,
  output logic [tlc_pkg::IMGN_W-1:0] n_lim,
  output logic [CG_W-1:0]           cg_lim,
  output logic [WG_W-1:0]           wg_lim,
  output logic                      ident
);

  localparam int NUMC_W  = $clog2(MAX_DIM + CHANNEL_LANES);
  localparam int CG_S    = NUMC_W + $clog2(CHANNEL_LANES);
  localparam int CG_M    = ((1 << CG_S) + CHANNEL_LANES - 1) / CHANNEL_LANES;
  localparam int PRODC_W = NUMC_W + $clog2(CG_M + 1);
  localparam int NUMW_W  = $clog2(MAX_DIM + WIDTH_LANES);
  localparam int WG_S    = NUMW_W + $clog2(WIDTH_LANES);
  localparam int WG_M    = ((1 << WG_S) + WIDTH_LANES - 1) / WIDTH_LANES;
  localparam int PRODW_W = NUMW_W + $clog2(WG_M + 1);

  localparam int RST_H  = (tlc_pkg::RST_HEIGHT > MAX_DIM) ? MAX_DIM : tlc_pkg::RST_HEIGHT;
  localparam int RST_W  = (tlc_pkg::RST_WIDTH > MAX_DIM) ? MAX_DIM : tlc_pkg::RST_WIDTH;
  localparam int RST_CG = (tlc_pkg::RST_CHANNELS + CHANNEL_LANES - 1) / CHANNEL_LANES;
  localparam int RST_WG = (RST_W + WIDTH_LANES - 1) / WIDTH_LANES;

  logic [DIM_W-1:0]            c_lim_r, h_lim_r, w_lim_r;
  logic [tlc_pkg::IMGN_W-1:0]  n_lim_r;
  logic [CG_W-1:0]             cg_lim_r;
  logic [WG_W-1:0]             wg_lim_r;
  logic                        ident_r;

  logic                        wr;
  logic [DIM_W-1:0]            dim_val;
  logic [tlc_pkg::IMGN_W-1:0]  img_val;
  logic [NUMC_W-1:0]           c_num;
  logic [NUMW_W-1:0]           w_num;
  logic [PRODC_W-1:0]          c_prod;
  logic [PRODW_W-1:0]          w_prod;

  assign cfg_chan.ready = 1'b1;
  assign wr = cfg_chan.valid;

  always_comb begin
    if (cfg_chan.data == '0) begin
      dim_val = DIM_W'(1);
    end else if (int'(cfg_chan.data) > MAX_DIM) begin
      dim_val = DIM_W'(MAX_DIM);
    end else begin
      dim_val = DIM_W'(cfg_chan.data);
    end
    if (cfg_chan.data[tlc_pkg::IMGN_W-1:0] == '0) begin
      img_val = tlc_pkg::IMGN_W'(1);
    end else if (int'(cfg_chan.data[tlc_pkg::IMGN_W-1:0]) > tlc_pkg::MAX_IMAGES) begin
      img_val = tlc_pkg::IMGN_W'(tlc_pkg::MAX_IMAGES);
    end else begin
      img_val = cfg_chan.data[tlc_pkg::IMGN_W-1:0];
    end
  end

  assign c_num  = NUMC_W'(dim_val) + NUMC_W'(CHANNEL_LANES - 1);
  assign w_num  = NUMW_W'(dim_val) + NUMW_W'(WIDTH_LANES - 1);
  assign c_prod = PRODC_W'(c_num) * PRODC_W'(CG_M);
  assign w_prod = PRODW_W'(w_num) * PRODW_W'(WG_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_lim_r  <= DIM_W'(tlc_pkg::RST_CHANNELS);
      h_lim_r  <= DIM_W'(RST_H);
      w_lim_r  <= DIM_W'(RST_W);
      n_lim_r  <= tlc_pkg::IMGN_W'(tlc_pkg::RST_IMAGES);
      cg_lim_r <= CG_W'(RST_CG);
      wg_lim_r <= WG_W'(RST_WG);
      ident_r  <= 1'b0;
    end else if (wr) begin
      case (cfg_chan.index)
        tlc_pkg::REG_CHANNEL_COUNT: begin
          c_lim_r  <= dim_val;
          cg_lim_r <= CG_W'(c_prod >> CG_S);
        end
        tlc_pkg::REG_HEIGHT: begin
          h_lim_r <= dim_val;
        end
        tlc_pkg::REG_WIDTH: begin
          w_lim_r  <= dim_val;
          wg_lim_r <= WG_W'(w_prod >> WG_S);
        end
        tlc_pkg::REG_IMAGE_COUNT: begin
          n_lim_r <= img_val;
        end
        tlc_pkg::REG_IDENTITY_MODE: begin
          ident_r <= cfg_chan.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign c_lim  = c_lim_r;
  assign h_lim  = h_lim_r;
  assign w_lim  = w_lim_r;
  assign n_lim  = n_lim_r;
  assign cg_lim = cg_lim_r;
  assign wg_lim = wg_lim_r;
  assign ident  = ident_r;

endmodule

`default_nettype wire

FILE: hdl/tlc_ctrl.sv
// Sequencer that steps the shared multiply-accumulate unit for each request.
`default_nettype none

module tlc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tlc_pkg::dp_stat_t stat,
  output tlc_pkg::dp_cmd_t  cmd
);

  tlc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.accept = 1'b0;
    cmd.op     = tlc_pkg::MAC_HOLD;
    cmd.emit   = 1'b0;
    case (state_r)
      tlc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = tlc_pkg::ST_SRC_ROW;
        end
      end
      tlc_pkg::ST_SRC_ROW: begin
        cmd.op    = tlc_pkg::MAC_SRC_ROW;
        state_nxt = tlc_pkg::ST_SRC_COL;
      end
      tlc_pkg::ST_SRC_COL: begin
        cmd.op    = tlc_pkg::MAC_SRC_COL;
        state_nxt = tlc_pkg::ST_DST_GRP;
      end
      tlc_pkg::ST_DST_GRP: begin
        cmd.op    = tlc_pkg::MAC_DST_GRP;
        state_nxt = tlc_pkg::ST_DST_ROW;
      end
      tlc_pkg::ST_DST_ROW: begin
        cmd.op    = tlc_pkg::MAC_DST_ROW;
        state_nxt = tlc_pkg::ST_DST_COL;
      end
      tlc_pkg::ST_DST_COL: begin
        cmd.op    = tlc_pkg::MAC_DST_COL;
        state_nxt = tlc_pkg::ST_EMIT;
      end
      tlc_pkg::ST_EMIT: begin
        // hold until the output register frees up
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = tlc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tlc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/tlc_dpath.sv
// Counter nest, shared multiply-accumulate unit and output register.
`default_nettype none

module tlc_dpath #(
  parameter int CHANNEL_LANES = tlc_pkg::CHANNEL_LANES_DEF,
  parameter int WIDTH_LANES   = tlc_pkg::WIDTH_LANES_DEF,
  parameter int MAX_DIM       = tlc_pkg::MAX_DIM_DEF,
  localparam int DIM_W = $clog2(MAX_DIM + 1),
  localparam int CGMAX = (MAX_DIM + CHANNEL_LANES - 1) / CHANNEL_LANES,
  localparam int WGMAX = (MAX_DIM + WIDTH_LANES - 1) / WIDTH_LANES,
  localparam int CG_W  = $clog2(CGMAX + 1),
  localparam int WG_W  = $clog2(WGMAX + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       restart,
  input  tlc_pkg::dp_cmd_t           cmd,
  output tlc_pkg::dp_stat_t          stat,
  input  logic [DIM_W-1:0]           c_lim,
  input  logic [DIM_W-1:0]           h_lim,
  input  logic [DIM_W-1:0]           w_lim,
  input  logic [tlc_pkg::IMGN_W-1:0] n_lim,
  input  logic [CG_W-1:0]            cg_lim,
  input  logic [WG_W-1:0]            wg_lim,
  input  logic                       ident,
  tlc_out_if.source                  out_chan
);

  localparam int DW     = tlc_pkg::DEST_W;
  localparam int CLW    = (CHANNEL_LANES > 1) ? $clog2(CHANNEL_LANES) : 1;
  localparam int WLW    = (WIDTH_LANES > 1) ? $clog2(WIDTH_LANES) : 1;
  localparam int CGC_W  = (CGMAX > 1) ? $clog2(CGMAX) : 1;
  localparam int WGC_W  = (WGMAX > 1) ? $clog2(WGMAX) : 1;
  localparam int ROW_W  = $clog2(MAX_DIM);
  localparam int LINC_W = $clog2(CGMAX * CHANNEL_LANES);
  localparam int LINW_W = $clog2(WGMAX * WIDTH_LANES);
  localparam int CMPC_W = (LINC_W > DIM_W) ? LINC_W : DIM_W;
  localparam int CMPW_W = (LINW_W > DIM_W) ? LINW_W : DIM_W;
  localparam int PSH    = $clog2(WIDTH_LANES * CHANNEL_LANES);
  localparam int OFF_W  = $clog2(WIDTH_LANES * CHANNEL_LANES + 1);
  localparam int PROD_W = DW + DIM_W;

  logic [CLW-1:0]             cl_r;
  logic [WLW-1:0]             wl_r;
  logic [WGC_W-1:0]           colg_r;
  logic [ROW_W-1:0]           row_r;
  logic [CGC_W-1:0]           cg_r;
  logic [tlc_pkg::IMG_W-1:0]  img_r;

  logic [DW-1:0]              acc_r;
  logic [DW-1:0]              src_r;

  logic                       out_valid_r;
  logic [DW-1:0]              dest_r;
  logic [tlc_pkg::SRC_W-1:0]  src_out_r;
  logic                       zero_fill_r;
  logic                       last_r;

  logic cl_wrap, wl_wrap, colg_wrap, row_wrap, cg_wrap, img_wrap, last;
  logic [LINC_W-1:0]  lin_c;
  logic [LINW_W-1:0]  lin_w;
  logic               zero_fill;
  logic [OFF_W-1:0]   lane_off;
  logic [DW-1:0]      dest_nxt;

  logic [DW-1:0]      mac_a, mac_c, mac_sum;
  logic [DIM_W-1:0]   mac_b;
  logic [PROD_W-1:0]  mac_prod;

  assign cl_wrap   = (cl_r == CLW'(CHANNEL_LANES - 1));
  assign wl_wrap   = (wl_r == WLW'(WIDTH_LANES - 1));
  assign colg_wrap = (WG_W'(colg_r) + WG_W'(1) >= wg_lim);
  assign row_wrap  = (DIM_W'(row_r) + DIM_W'(1) >= h_lim);
  assign cg_wrap   = (CG_W'(cg_r) + CG_W'(1) >= cg_lim);
  assign img_wrap  = (tlc_pkg::IMGN_W'(img_r) + tlc_pkg::IMGN_W'(1) >= n_lim);
  assign last      = cl_wrap && wl_wrap && colg_wrap && row_wrap && cg_wrap && img_wrap;

  assign lin_c = LINC_W'(cg_r) * LINC_W'(CHANNEL_LANES) + LINC_W'(cl_r);
  assign lin_w = LINW_W'(colg_r) * LINW_W'(WIDTH_LANES) + LINW_W'(wl_r);
  assign zero_fill = (CMPC_W'(lin_c) >= CMPC_W'(c_lim)) || (CMPW_W'(lin_w) >= CMPW_W'(w_lim));

  assign lane_off = OFF_W'(wl_r) * OFF_W'(CHANNEL_LANES) + OFF_W'(cl_r);
  assign dest_nxt = ident ? src_r : (acc_r << PSH) + DW'(lane_off);

  always_comb begin
    mac_a = acc_r;
    mac_b = h_lim;
    mac_c = DW'(row_r);
    case (cmd.op)
      tlc_pkg::MAC_SRC_ROW: begin
        mac_a = DW'(lin_c);
        mac_b = h_lim;
        mac_c = DW'(row_r);
      end
      tlc_pkg::MAC_SRC_COL: begin
        mac_a = acc_r;
        mac_b = w_lim;
        mac_c = DW'(lin_w);
      end
      tlc_pkg::MAC_DST_GRP: begin
        mac_a = DW'(img_r);
        mac_b = DIM_W'(cg_lim);
        mac_c = DW'(cg_r);
      end
      tlc_pkg::MAC_DST_ROW: begin
        mac_a = acc_r;
        mac_b = h_lim;
        mac_c = DW'(row_r);
      end
      tlc_pkg::MAC_DST_COL: begin
        mac_a = acc_r;
        mac_b = DIM_W'(wg_lim);
        mac_c = DW'(colg_r);
      end
      default: begin
      end
    endcase
  end

  assign mac_prod = PROD_W'(mac_a) * PROD_W'(mac_b);
  assign mac_sum  = DW'(mac_prod) + mac_c;

  always_ff @(posedge clk) begin
    if (cmd.op != tlc_pkg::MAC_HOLD) begin
      acc_r <= mac_sum;
    end
    if (cmd.op == tlc_pkg::MAC_SRC_COL) begin
      src_r <= mac_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_r   <= '0;
      wl_r   <= '0;
      colg_r <= '0;
      row_r  <= '0;
      cg_r   <= '0;
      img_r  <= '0;
    end else if (cmd.accept && restart) begin
      cl_r   <= '0;
      wl_r   <= '0;
      colg_r <= '0;
      row_r  <= '0;
      cg_r   <= '0;
      img_r  <= '0;
    end else if (cmd.emit) begin
      cl_r <= cl_wrap ? '0 : cl_r + CLW'(1);
      if (cl_wrap) begin
        wl_r <= wl_wrap ? '0 : wl_r + WLW'(1);
      end
      if (cl_wrap && wl_wrap) begin
        colg_r <= colg_wrap ? '0 : colg_r + WGC_W'(1);
      end
      if (cl_wrap && wl_wrap && colg_wrap) begin
        row_r <= row_wrap ? '0 : row_r + ROW_W'(1);
      end
      if (cl_wrap && wl_wrap && colg_wrap && row_wrap) begin
        cg_r <= cg_wrap ? '0 : cg_r + CGC_W'(1);
      end
      if (cl_wrap && wl_wrap && colg_wrap && row_wrap && cg_wrap) begin
        img_r <= img_wrap ? '0 : img_r + tlc_pkg::IMG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      dest_r      <= dest_nxt;
      src_out_r   <= src_r[tlc_pkg::SRC_W-1:0];
      zero_fill_r <= zero_fill;
      last_r      <= last;
    end
  end

  assign stat.out_busy = out_valid_r && !out_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.dest_addr    = dest_r;
  assign out_chan.src_addr     = src_out_r;
  assign out_chan.zero_fill    = zero_fill_r;
  assign out_chan.last_element = last_r;

endmodule

`default_nettype wire

FILE: hdl/tensor_layout_convert_addr_gen.sv
// Top level of the CHW to blocked layout address generator.
//
//   channel   dir  payload                                        handshake
//   in_chan   in   restart                                        valid/ready
//   out_chan  out  dest_addr, src_addr, zero_fill, last_element   valid/ready
//   cfg_chan  in   index, data                                    valid/ready
//
// Each request steps through accept, five passes through the shared
// 34 x 11 multiply-accumulate unit, and one load into the output register.
// Synchronous reset clears the sequencer, the counter nest and the output
// valid, and loads the register defaults; no clearing pass follows.
// A stalled result waits in the output register; the next request is
// accepted meanwhile and holds in its last step until the register frees.
`default_nettype none

module tensor_layout_convert_addr_gen #(
  parameter int CHANNEL_LANES = tlc_pkg::CHANNEL_LANES_DEF,
  parameter int WIDTH_LANES   = tlc_pkg::WIDTH_LANES_DEF,
  parameter int MAX_DIM       = tlc_pkg::MAX_DIM_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tlc_in_if.sink    in_chan,
  tlc_out_if.source out_chan,
  tlc_cfg_if.sink   cfg_chan
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CGMAX = (MAX_DIM + CHANNEL_LANES - 1) / CHANNEL_LANES;
  localparam int WGMAX = (MAX_DIM + WIDTH_LANES - 1) / WIDTH_LANES;
  localparam int CG_W  = $clog2(CGMAX + 1);
  localparam int WG_W  = $clog2(WGMAX + 1);

  logic [DIM_W-1:0]           c_lim, h_lim, w_lim;
  logic [tlc_pkg::IMGN_W-1:0] n_lim;
  logic [CG_W-1:0]            cg_lim;
  logic [WG_W-1:0]            wg_lim;
  logic                       ident;
  tlc_pkg::dp_cmd_t           cmd;
  tlc_pkg::dp_stat_t          stat;

  tlc_cfg #(
    .CHANNEL_LANES (CHANNEL_LANES),
    .WIDTH_LANES   (WIDTH_LANES),
    .MAX_DIM       (MAX_DIM)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .c_lim    (c_lim),
    .h_lim    (h_lim),
    .w_lim    (w_lim),
    .n_lim    (n_lim),
    .cg_lim   (cg_lim),
    .wg_lim   (wg_lim),
    .ident    (ident)
  );

  tlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlc_dpath #(
    .CHANNEL_LANES (CHANNEL_LANES),
    .WIDTH_LANES   (WIDTH_LANES),
    .MAX_DIM       (MAX_DIM)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .restart  (in_chan.restart),
    .cmd      (cmd),
    .stat     (stat),
    .c_lim    (c_lim),
    .h_lim    (h_lim),
    .w_lim    (w_lim),
    .n_lim    (n_lim),
    .cg_lim   (cg_lim),
    .wg_lim   (wg_lim),
    .ident    (ident),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

FILE: hdl/tlc_checker.sv
// Port-level checker for the layout address generator, bound to the top level.
`default_nettype none

module tlc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tlc_pkg::DEST_W-1:0] out_dest_addr
);

  logic       in_acc, out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("ready stayed high after a request was taken");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result shown without an outstanding request");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 2'd2)
    else $error("more than two requests outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dest_addr))
    else $error("stalled result changed or dropped");

endmodule

bind tensor_layout_convert_addr_gen tlc_checker u_tlc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_dest_addr (out_chan.dest_addr)
);

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the CHW to blocked layout address generator.
`timescale 1ns / 100ps

module testbench;

  localparam int CH_LANES = tlc_pkg::CHANNEL_LANES_DEF;
  localparam int W_LANES  = tlc_pkg::WIDTH_LANES_DEF;
  localparam int MAX_DIM  = tlc_pkg::MAX_DIM_DEF;

  localparam int LV_C_LANE  = 0;
  localparam int LV_W_LANE  = 1;
  localparam int LV_COL_GRP = 2;
  localparam int LV_ROW     = 3;
  localparam int LV_CH_GRP  = 4;
  localparam int LV_IMAGE   = 5;
  localparam int LEVELS     = 6;

  localparam logic [tlc_pkg::CFG_IDX_W-1:0]  REG_UNUSED    = 3'd7;
  localparam logic [tlc_pkg::CFG_DATA_W-1:0] DATA_ALL_ONES = '1;

  localparam int unsigned ITEMS        = 1600;
  localparam int unsigned CALM_AT      = ITEMS - 250;
  localparam int unsigned HOLD_AT      = 24;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE       = 12;
  localparam int unsigned DRAIN_LIMIT  = 20000;
  localparam int unsigned MAX_PASS     = 640;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct {
    logic [tlc_pkg::DEST_W-1:0] dest;
    logic [tlc_pkg::SRC_W-1:0]  src;
    logic                       zero_fill;
    logic                       last;
  } elem_addr_t;

  class layout_addr_book;
    logic [tlc_pkg::CFG_DATA_W-1:0] channels, rows, cols;
    logic [tlc_pkg::IMGN_W-1:0]     images;
    logic                           identity;
    int unsigned                    nest [LEVELS];
    longint unsigned                slot;
    elem_addr_t                     expected_addrs [$];
    int unsigned                    failures;

    function new();
      channels = tlc_pkg::CFG_DATA_W'(tlc_pkg::RST_CHANNELS);
      rows     = tlc_pkg::CFG_DATA_W'(tlc_pkg::RST_HEIGHT);
      cols     = tlc_pkg::CFG_DATA_W'(tlc_pkg::RST_WIDTH);
      images   = tlc_pkg::IMGN_W'(tlc_pkg::RST_IMAGES);
      identity = 1'b0;
      foreach (nest[i]) nest[i] = 0;
      failures = 0;
      slot = 1;
      while (slot < CH_LANES * W_LANES) slot = slot << 1;
    endfunction

    function int unsigned fit(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void complain(string what);
      failures++;
      if (failures <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
    endfunction

    function void write_reg(logic [tlc_pkg::CFG_IDX_W-1:0] idx,
                            logic [tlc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        tlc_pkg::REG_CHANNEL_COUNT: channels = data;
        tlc_pkg::REG_HEIGHT:        rows = data;
        tlc_pkg::REG_WIDTH:         cols = data;
        tlc_pkg::REG_IMAGE_COUNT:   images = data[tlc_pkg::IMGN_W-1:0];
        tlc_pkg::REG_IDENTITY_MODE: identity = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(bit restart);
      int unsigned     lim [LEVELS];
      int unsigned     c_n, h_n, w_n;
      int              lv;
      longint unsigned lin_c, lin_w, src, dest;
      bit              last_pos;
      elem_addr_t      e;
      c_n = fit(channels, MAX_DIM);
      h_n = fit(rows, MAX_DIM);
      w_n = fit(cols, MAX_DIM);
      lim[LV_C_LANE]  = CH_LANES;
      lim[LV_W_LANE]  = W_LANES;
      lim[LV_COL_GRP] = (w_n + W_LANES - 1) / W_LANES;
      lim[LV_ROW]     = h_n;
      lim[LV_CH_GRP]  = (c_n + CH_LANES - 1) / CH_LANES;
      lim[LV_IMAGE]   = fit(images, tlc_pkg::MAX_IMAGES);
      if (restart) foreach (nest[i]) nest[i] = 0;
      lin_c = 64'(nest[LV_CH_GRP]) * CH_LANES + nest[LV_C_LANE];
      lin_w = 64'(nest[LV_COL_GRP]) * W_LANES + nest[LV_W_LANE];
      src = lin_c * h_n * w_n + 64'(nest[LV_ROW]) * w_n + lin_w;
      dest = (((64'(nest[LV_IMAGE]) * lim[LV_CH_GRP] + nest[LV_CH_GRP]) * h_n
              + nest[LV_ROW]) * lim[LV_COL_GRP] + nest[LV_COL_GRP]) * slot
             + 64'(nest[LV_W_LANE]) * CH_LANES + nest[LV_C_LANE];
      if (identity) dest = src;
      last_pos = 1'b1;
      foreach (nest[i]) if (nest[i] + 1 < lim[i]) last_pos = 1'b0;
      e.dest      = dest[tlc_pkg::DEST_W-1:0];
      e.src       = src[tlc_pkg::SRC_W-1:0];
      e.zero_fill = (lin_c >= c_n) || (lin_w >= w_n);
      e.last      = last_pos;
      expected_addrs.push_back(e);
      for (lv = 0; lv < LEVELS; lv++) begin
        if (nest[lv] + 1 >= lim[lv]) begin
          nest[lv] = 0;
        end else begin
          nest[lv]++;
          break;
        end
      end
    endfunction

    function void check_result(logic [tlc_pkg::DEST_W-1:0] dest,
                               logic [tlc_pkg::SRC_W-1:0] src,
                               logic zf, logic last);
      elem_addr_t e;
      if (expected_addrs.size() == 0) begin
        complain($sformatf("unexpected result dest=%h src=%h zf=%b last=%b",
                           dest, src, zf, last));
        return;
      end
      e = expected_addrs.pop_front();
      if (dest !== e.dest || src !== e.src || zf !== e.zero_fill || last !== e.last)
        complain($sformatf("exp dest=%h src=%h zf=%b last=%b / got dest=%h src=%h zf=%b last=%b",
                           e.dest, e.src, e.zero_fill, e.last, dest, src, zf, last));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  tlc_in_if  in_if ();
  tlc_out_if out_if ();
  tlc_cfg_if cfg_if ();

  tensor_layout_convert_addr_gen dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  layout_addr_book book = new();
  int unsigned sent = 0;
  bit calm = 1'b0;
  bit held = 1'b0;

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      book.check_result(out_if.dest_addr, out_if.src_addr, out_if.zero_fill,
                        out_if.last_element);
  end

  initial begin
    forever begin
      if (!held && sent >= HOLD_AT) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_request(input bit restart);
    in_if.valid   <= 1'b1;
    in_if.restart <= restart;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    book.note_request(restart);
    sent++;
    calm = (sent >= CALM_AT);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (book.expected_addrs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tlc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tlc_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    book.write_reg(idx, data);
  endtask

  task automatic set_shape(input int unsigned c, h, w, n, input bit ident);
    write_reg(tlc_pkg::REG_CHANNEL_COUNT, tlc_pkg::CFG_DATA_W'(c));
    write_reg(tlc_pkg::REG_HEIGHT, tlc_pkg::CFG_DATA_W'(h));
    write_reg(tlc_pkg::REG_WIDTH, tlc_pkg::CFG_DATA_W'(w));
    write_reg(tlc_pkg::REG_IMAGE_COUNT, tlc_pkg::CFG_DATA_W'(n));
    write_reg(tlc_pkg::REG_IDENTITY_MODE, tlc_pkg::CFG_DATA_W'(ident));
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, tlc_pkg::CFG_DATA_W'($urandom));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic run_phase(input bit lead, input int unsigned count,
                           input int unsigned noise_pct);
    int unsigned k;
    for (k = 0; k < count; k++)
      send_request(k == 0 ? lead : ($urandom_range(0, 99) < noise_pct));
    wait_idle();
  endtask

  function automatic int unsigned pass_items(int unsigned c, h, w, n);
    return book.fit(n, tlc_pkg::MAX_IMAGES) * ((book.fit(c, MAX_DIM) + CH_LANES - 1) / CH_LANES)
           * book.fit(h, MAX_DIM) * ((book.fit(w, MAX_DIM) + W_LANES - 1) / W_LANES)
           * CH_LANES * W_LANES;
  endfunction

  function automatic int unsigned any_dim();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return DATA_ALL_ONES;
      2:       return MAX_DIM;
      3:       return 1;
      default: return $urandom_range(1, DATA_ALL_ONES);
    endcase
  endfunction

  initial begin
    int unsigned c, h, w, n, pick;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.restart <= 1'b0;
    cfg_if.valid  <= 1'b0;
    cfg_if.index  <= tlc_pkg::REG_CHANNEL_COUNT;
    cfg_if.data   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_phase(1'b1, 4, 0);
    set_shape(DATA_ALL_ONES, 0, 0, 31, 1'b1);
    run_phase(1'b1, 4, 0);
    set_shape(0, DATA_ALL_ONES, MAX_DIM, 0, 1'b0);
    run_phase(1'b1, 4, 0);
    write_reg(REG_UNUSED, DATA_ALL_ONES);
    set_shape(MAX_DIM, MAX_DIM, 1, tlc_pkg::MAX_IMAGES, 1'b0);
    run_phase(1'b0, 3, 0);
    set_shape(1000, 777, 1023, tlc_pkg::MAX_IMAGES, 1'b1);
    run_phase(1'b1, 3, 0);
    run_phase(1'b0, 40, 0);

    while (sent < ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        // jump to random and edge-case shapes, usually with the counters carried over
        set_shape(any_dim(), any_dim(), any_dim(), $urandom_range(0, 31),
                  $urandom_range(0, 1) == 1);
        run_phase($urandom_range(0, 3) == 0, $urandom_range(8, 40), 3);
      end else if (pick == 2) begin
        // sweep the image counter with the smallest slots
        set_shape($urandom_range(1, CH_LANES), 1, $urandom_range(1, W_LANES),
                  $urandom_range(2, tlc_pkg::MAX_IMAGES), $urandom_range(0, 4) == 0);
        run_phase(1'b1, CH_LANES * W_LANES * $urandom_range(1, 4), 0);
      end else begin
        do begin
          c = $urandom_range(0, 40);
          h = $urandom_range(0, 3);
          w = $urandom_range(0, 24);
          n = $urandom_range(0, 2);
        end while (pass_items(c, h, w, n) > MAX_PASS);
        set_shape(c, h, w, n, $urandom_range(0, 4) == 0);
        run_phase($urandom_range(0, 6) != 0, pass_items(c, h, w, n) + $urandom_range(0, 130),
                  2);
      end
    end

    in_if.valid <= 1'b0;
    for (c = 0; c < DRAIN_LIMIT && book.expected_addrs.size() != 0; c++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (book.expected_addrs.size() != 0)
      book.complain($sformatf("%0d results never arrived", book.expected_addrs.size()));
    if (book.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/tlc_pkg.sv
hdl/tlc_in_if.sv
hdl/tlc_out_if.sv
hdl/tlc_cfg_if.sv
hdl/tlc_cfg.sv
hdl/tlc_ctrl.sv
hdl/tlc_dpath.sv
hdl/tensor_layout_convert_addr_gen.sv
hdl/tlc_checker.sv
tb/testbench.sv
